@@ hw/rtl/rclsm_pkg.sv @@
// rclsm_pkg: operation, status and register codes of the row cache slot manager
// plus the command and status structs between controller and datapath
// no dependencies
package rclsm_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_REBASE = 2'd2;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_ALLOC   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_REBASED = 3'd4;
    localparam logic [2:0] ST_BAD     = 3'd5;

    localparam logic [1:0] CFG_MAX_SLOTS    = 2'd0;
    localparam logic [1:0] CFG_NUM_VECTORS  = 2'd1;
    localparam logic [1:0] CFG_ACTIVE_COUNT = 2'd2;

    localparam int BaseMax = 262143;

    typedef enum logic [1:0] {
        SCAN_FREE,
        SCAN_EVICT,
        SCAN_MAX,
        SCAN_SUB
    } scan_mode_t;

    typedef struct packed {
        logic       clear;
        logic       load;
        logic       row_rd;
        logic       take_hit;
        logic       touch;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       evict;
        logic       commit;
        logic       mul;
        logic       emit;
        logic [2:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       bad;
        logic       row_hit;
        logic       full;
        logic       scan_busy;
        logic       found;
        logic       vfound;
        logic       ev;
        logic       clear_last;
    } dp_stat_t;

endpackage

@@ hw/rtl/rclsm_dp.sv @@
// rclsm_dp: datapath of the row cache slot manager; config registers, row and
// slot memories, slot scan engine, base address multiplier and result registers
// depends on rclsm_pkg
module rclsm_dp
    import rclsm_pkg::*;
#(
    parameter int ROWS  = 1024,
    parameter int SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic [1:0]  op,
    input  logic [10:0] row,
    input  logic [30:0] now,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  slot,
    output logic [17:0] base_addr,
    output logic        evicted,
    output logic [9:0]  evicted_row
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int DEPTH = (ROWS > SLOTS) ? ROWS : SLOTS;
    localparam int KW    = $clog2(DEPTH);
    localparam int PW    = SW + 11;

    logic [8:0]  max_slots_reg;
    logic [10:0] num_vectors_reg;
    logic [10:0] active_count_reg;

    logic [1:0]  op_reg;
    logic [10:0] row_reg;
    logic [30:0] now_reg;

    logic signed [12:0] fold_s;
    logic [RW-1:0]      row_idx;
    logic               row_bad;
    logic [CW-1:0]      lim;

    logic [CW-1:0] used_count_reg;
    logic [KW-1:0] clr_cnt_reg;

    scan_mode_t    mode_reg;
    logic          issue_reg;
    logic [CW-1:0] scan_cnt_reg;
    logic          pipe_vld_reg;
    logic [SW-1:0] pipe_idx_reg;
    logic [SW-1:0] scan_addr;

    logic               found_reg;
    logic [SW-1:0]      free_idx_reg;
    logic               vfound_reg;
    logic [SW-1:0]      victim_reg;
    logic [RW-1:0]      victim_row_reg;
    logic signed [32:0] least_reg;
    logic signed [31:0] mx_reg;
    logic               ev_reg;
    logic [SW-1:0]      s_reg;
    logic [PW-1:0]      prod_reg;

    logic [SW:0]        row_mem [ROWS];
    logic [RW:0]        meta_mem [SLOTS];
    logic signed [31:0] stamp_mem [SLOTS];

    logic [SW:0]        row_rd_reg;
    logic [RW:0]        meta_rd_reg;
    logic signed [31:0] stamp_rd_reg;

    logic               row_we;
    logic [RW-1:0]      row_wa;
    logic [SW:0]        row_wd;
    logic               meta_we;
    logic [SW-1:0]      meta_wa;
    logic [RW:0]        meta_wd;
    logic               stamp_we;
    logic [SW-1:0]      stamp_wa;
    logic signed [31:0] stamp_wd;

    logic signed [32:0] sub_diff;
    logic signed [31:0] sub_val;
    logic               has_slot;
    logic [17:0]        base_sat;

    logic        done_reg;
    logic [2:0]  status_reg;
    logic [7:0]  slot_reg;
    logic [17:0] base_reg;
    logic        evicted_reg;
    logic [9:0]  evicted_row_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_slots_reg    <= 9'd256;
            num_vectors_reg  <= 11'd1024;
            active_count_reg <= 11'd1024;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_SLOTS:    max_slots_reg    <= cfg_data[8:0];
                CFG_NUM_VECTORS:  num_vectors_reg  <= cfg_data;
                CFG_ACTIVE_COUNT: active_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            row_reg <= row;
            now_reg <= now;
        end
    end

    // row folding and range check
    always_comb
    begin
        if (row_reg >= num_vectors_reg)
        begin
            fold_s = $signed({1'b0, num_vectors_reg, 1'b0}) - 13'sd1
                     - $signed({2'b00, row_reg});
        end
        else
        begin
            fold_s = $signed({2'b00, row_reg});
        end
        row_bad = fold_s[12] || (32'(fold_s[11:0]) >= 32'(ROWS));
        row_idx = RW'(fold_s[11:0]);
    end

    assign lim = (32'(max_slots_reg) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(max_slots_reg);

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // slot scan: issue one address a cycle, evaluate its read data in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= SCAN_FREE;
            issue_reg    <= 1'b0;
            scan_cnt_reg <= '0;
            pipe_vld_reg <= 1'b0;
            pipe_idx_reg <= '0;
        end
        else if (cmd.scan_start)
        begin
            mode_reg     <= cmd.scan_mode;
            scan_cnt_reg <= '0;
            issue_reg    <= (lim != '0);
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            pipe_vld_reg <= issue_reg;
            if (issue_reg)
            begin
                pipe_idx_reg <= scan_cnt_reg[SW-1:0];
                scan_cnt_reg <= CW'(scan_cnt_reg + 1'b1);
                if (CW'(scan_cnt_reg + 1'b1) == lim)
                begin
                    issue_reg <= 1'b0;
                end
            end
        end
    end

    assign scan_addr = scan_cnt_reg[SW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg  <= 1'b0;
            vfound_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            found_reg  <= 1'b0;
            vfound_reg <= 1'b0;
            least_reg  <= $signed({2'b00, now_reg}) + 33'sd1;
            // the subtract pass keeps the maximum found by the max pass
            if (cmd.scan_mode == SCAN_MAX)
            begin
                mx_reg <= '0;
            end
        end
        else if (pipe_vld_reg)
        begin
            unique case (mode_reg)
                SCAN_FREE:
                begin
                    if (!found_reg && !meta_rd_reg[RW])
                    begin
                        found_reg    <= 1'b1;
                        free_idx_reg <= pipe_idx_reg;
                    end
                end
                SCAN_EVICT:
                begin
                    if (meta_rd_reg[RW] && (stamp_rd_reg < least_reg))
                    begin
                        vfound_reg     <= 1'b1;
                        least_reg      <= 33'(stamp_rd_reg);
                        victim_reg     <= pipe_idx_reg;
                        victim_row_reg <= meta_rd_reg[RW-1:0];
                    end
                end
                SCAN_MAX:
                begin
                    if (stamp_rd_reg > mx_reg)
                    begin
                        mx_reg <= stamp_rd_reg;
                    end
                end
                SCAN_SUB: ;
                default:  ;
            endcase
        end
    end

    // saturating rebase subtract
    always_comb
    begin
        sub_diff = $signed({stamp_rd_reg[31], stamp_rd_reg}) - $signed({mx_reg[31], mx_reg});
        if (sub_diff[32:31] == 2'b10)
        begin
            sub_val = 32'sh8000_0000;
        end
        else
        begin
            sub_val = sub_diff[31:0];
        end
    end

    // memory write port selection
    always_comb
    begin
        row_we   = 1'b0;
        row_wa   = row_idx;
        row_wd   = {1'b1, free_idx_reg};
        meta_we  = 1'b0;
        meta_wa  = free_idx_reg;
        meta_wd  = {1'b1, row_idx};
        stamp_we = 1'b0;
        stamp_wa = free_idx_reg;
        stamp_wd = $signed({1'b0, now_reg});
        if (cmd.clear)
        begin
            row_we   = 32'(clr_cnt_reg) < 32'(ROWS);
            row_wa   = clr_cnt_reg[RW-1:0];
            row_wd   = '0;
            meta_we  = 32'(clr_cnt_reg) < 32'(SLOTS);
            meta_wa  = clr_cnt_reg[SW-1:0];
            meta_wd  = '0;
            stamp_we = 32'(clr_cnt_reg) < 32'(SLOTS);
            stamp_wa = clr_cnt_reg[SW-1:0];
            stamp_wd = '0;
        end
        else if (cmd.evict)
        begin
            row_we  = 1'b1;
            row_wa  = victim_row_reg;
            row_wd  = '0;
            meta_we = 1'b1;
            meta_wa = victim_reg;
            meta_wd = '0;
        end
        else if (cmd.commit)
        begin
            row_we   = 1'b1;
            meta_we  = 1'b1;
            stamp_we = 1'b1;
        end
        else if (cmd.touch)
        begin
            stamp_we = 1'b1;
            stamp_wa = row_rd_reg[SW-1:0];
        end
        else if (pipe_vld_reg && (mode_reg == SCAN_SUB))
        begin
            stamp_we = 1'b1;
            stamp_wa = pipe_idx_reg;
            stamp_wd = sub_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        if (cmd.row_rd)
        begin
            row_rd_reg <= row_mem[row_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_wa] <= meta_wd;
        end
        meta_rd_reg <= meta_mem[scan_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_wa] <= stamp_wd;
        end
        stamp_rd_reg <= stamp_mem[scan_addr];
    end

    // used count and eviction flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
            ev_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.evict && (used_count_reg != '0))
            begin
                used_count_reg <= used_count_reg - 1'b1;
            end
            else if (cmd.commit)
            begin
                used_count_reg <= used_count_reg + 1'b1;
            end
            if (cmd.load)
            begin
                ev_reg <= 1'b0;
            end
            else if (cmd.evict)
            begin
                ev_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_hit)
        begin
            s_reg <= row_rd_reg[SW-1:0];
        end
        else if (cmd.commit)
        begin
            s_reg <= free_idx_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= {11'b0, s_reg} * {{SW{1'b0}}, active_count_reg};
        end
    end

    assign base_sat = (32'(prod_reg) > 32'(BaseMax)) ? 18'(BaseMax) : 18'(prod_reg);
    assign has_slot = (cmd.code == ST_HIT) || (cmd.code == ST_ALLOC);

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg      <= cmd.code;
            slot_reg        <= has_slot ? 8'(s_reg) : 8'd0;
            base_reg        <= has_slot ? base_sat : 18'd0;
            evicted_reg     <= ev_reg;
            evicted_row_reg <= ev_reg ? 10'(victim_row_reg) : 10'd0;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign base_addr   = base_reg;
    assign evicted     = evicted_reg;
    assign evicted_row = evicted_row_reg;

    assign stat.op         = op_reg;
    assign stat.bad        = row_bad;
    assign stat.row_hit    = row_rd_reg[SW];
    assign stat.full       = used_count_reg >= lim;
    assign stat.scan_busy  = issue_reg | pipe_vld_reg;
    assign stat.found      = found_reg;
    assign stat.vfound     = vfound_reg;
    assign stat.ev         = ev_reg;
    assign stat.clear_last = clr_cnt_reg == KW'(DEPTH - 1);

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    a_ev_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && evicted_reg) |-> (status_reg == ST_ALLOC || status_reg == ST_FULL))
        else $error("eviction reported with wrong status");

    a_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.evict || cmd.scan_start) |-> !(issue_reg || pipe_vld_reg))
        else $error("slot update while scan running");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (used_count_reg < CW'(SLOTS)))
        else $error("allocation with all slots used");
`endif

endmodule

@@ hw/rtl/rclsm_ctrl.sv @@
// rclsm_ctrl: controller state machine of the row cache slot manager
// sequences clearing, lookup, allocation scans and rebase passes in rclsm_dp
// depends on rclsm_pkg
module rclsm_ctrl
    import rclsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ROWW,
        S_FREE,
        S_EVICT,
        S_EVDONE,
        S_MAX,
        S_SUB,
        S_MUL,
        S_RESP
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] code_reg;
    logic [2:0] code_next;

    always_comb
    begin
        state_next    = state_reg;
        code_next     = code_reg;
        cmd           = '0;
        cmd.code      = code_reg;
        cmd.scan_mode = SCAN_FREE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.op == OP_REBASE)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_MAX;
                    state_next     = S_MAX;
                end
                else if ((stat.op == OP_LOOKUP || stat.op == OP_ALLOC) && !stat.bad)
                begin
                    cmd.row_rd = 1'b1;
                    state_next = S_ROWW;
                end
                else
                begin
                    code_next  = ST_BAD;
                    state_next = S_RESP;
                end
            end
            S_ROWW:
            begin
                if (stat.row_hit)
                begin
                    cmd.take_hit = 1'b1;
                    cmd.touch    = (stat.op == OP_LOOKUP);
                    code_next    = ST_HIT;
                    state_next   = S_MUL;
                end
                else if (stat.op == OP_LOOKUP)
                begin
                    code_next  = ST_MISS;
                    state_next = S_RESP;
                end
                else if (stat.full)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_EVICT;
                    state_next     = S_EVICT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_FREE;
                    state_next     = S_FREE;
                end
            end
            S_FREE:
            begin
                if (!stat.scan_busy)
                begin
                    if (stat.found)
                    begin
                        cmd.commit = 1'b1;
                        code_next  = ST_ALLOC;
                        state_next = S_MUL;
                    end
                    else if (stat.ev)
                    begin
                        code_next  = ST_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_EVICT;
                        state_next     = S_EVICT;
                    end
                end
            end
            S_EVICT:
            begin
                if (!stat.scan_busy)
                begin
                    if (stat.vfound)
                    begin
                        cmd.evict  = 1'b1;
                        state_next = S_EVDONE;
                    end
                    else
                    begin
                        code_next  = ST_FULL;
                        state_next = S_RESP;
                    end
                end
            end
            S_EVDONE:
            begin
                if (stat.full)
                begin
                    code_next  = ST_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_FREE;
                    state_next     = S_FREE;
                end
            end
            S_MAX:
            begin
                if (!stat.scan_busy)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_SUB;
                    state_next     = S_SUB;
                end
            end
            S_SUB:
            begin
                if (!stat.scan_busy)
                begin
                    code_next  = ST_REBASED;
                    state_next = S_RESP;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= ST_HIT;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ hw/rtl/row_cache_lru_slot_manager_unit.sv @@
// row_cache_lru_slot_manager_unit: top level of the lru row cache slot manager
// joins rclsm_ctrl and rclsm_dp; depends on rclsm_pkg
//
// usage:
//   command channel: drive op, row and now with start; a command is taken at
//   a clock edge with start high and busy low. busy stays high until the
//   result has been issued, one command at a time.
//   result channel: done is high for exactly one cycle with status, slot,
//   base_addr, evicted and evicted_row; the receiver cannot stall it.
//   config channel: cfg_valid with cfg_index and cfg_data, cfg_ready is
//   always high; write only while no command is in flight.
// command flow, from the accepted command to the done strobe:
//   bad row or unknown op: decode, response; miss: decode, row read, response
//   hit: decode, row read, base multiply, response; allocate with free room:
//   row read, one slot scan, base multiply, response; allocate with eviction:
//   victim scan, then free scan; rebase: max pass, then subtract pass
//   the slot scans read one slot entry a cycle from the slot memories
// reset: a clearing pass wipes the row and slot memories; busy is high during it,
//   config writes are still taken
module row_cache_lru_slot_manager_unit
    import rclsm_pkg::*;
#(
    parameter int ROWS  = 1024,
    parameter int SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [10:0] row,
    input  logic [30:0] now,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  slot,
    output logic [17:0] base_addr,
    output logic        evicted,
    output logic [9:0]  evicted_row,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rclsm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rclsm_dp #(
        .ROWS  (ROWS),
        .SLOTS (SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .row         (row),
        .now         (now),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .slot        (slot),
        .base_addr   (base_addr),
        .evicted     (evicted),
        .evicted_row (evicted_row)
    );

endmodule
